// ===== rtl/core/dbbp_pkg.sv =====
// Shared constants, codes and control types of the depth block back-projector.
`timescale 1ns / 1ps
package dbbp_pkg;

   localparam int DEF_MAX_WIDTH = 640;
   localparam int DEF_MAX_BLOCK = 8;

   localparam int DEPTH_W = 16;
   localparam int TIME_W  = 32;
   localparam int POINT_W = 18;
   localparam int COL_W   = 10;
   localparam int ROW_W   = 16;
   localparam int BS_W    = 4;
   localparam int SKIP_W  = 8;
   localparam int INV_W   = 24;
   localparam int CEN_W   = 14;
   localparam int SUM_W   = 22;
   localparam int CNT_W   = 7;
   localparam int DIV_W   = 23;
   localparam int POS_W   = 21;
   localparam int P1_W    = POS_W + INV_W;
   localparam int P2_W    = P1_W + DEPTH_W;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [DEPTH_W-1:0] MIN_DEPTH = 16'd300;
   localparam logic [SKIP_W-1:0]  SKIP_NONE = 8'hFF;

   localparam logic [COL_W-1:0]   RST_WIDTH  = 10'd640;
   localparam logic [BS_W-1:0]    RST_BLOCK  = 4'd5;
   localparam logic [DEPTH_W-1:0] RST_MAXD   = 16'd2200;
   localparam logic [SKIP_W-1:0]  RST_SKIP   = 8'd2;
   localparam logic [INV_W-1:0]   RST_INV_FX = 24'd27179;
   localparam logic [INV_W-1:0]   RST_INV_FY = 24'd27161;
   localparam logic [CEN_W-1:0]   RST_CX     = 14'd5220;
   localparam logic [CEN_W-1:0]   RST_CY     = 14'd3840;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DEPTH   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SKIP_FRAMES = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INV_FX      = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INV_FY      = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y    = 4'd7;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_FRAME,
      OP_DIV_COL,
      OP_WAIT_COL,
      OP_DIV_ROW,
      OP_WAIT_ROW,
      OP_DIV_WID,
      OP_WAIT_WID,
      OP_READ,
      OP_ACC,
      OP_DIV_MEAN,
      OP_WAIT_MEAN,
      OP_MUL1_X,
      OP_MUL2_X,
      OP_MUL1_Y,
      OP_MUL2_Y,
      OP_OUT,
      OP_ADV
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic resync;
      logic in_range;
      logic emit;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/dbbp_if.sv =====
// Request, result and register write channel interfaces.
`timescale 1ns / 1ps
interface dbbp_req_if;
   logic                           valid;
   logic                           ready;
   logic [dbbp_pkg::DEPTH_W-1:0]   depth_mm;
   logic                           frame_start;
   logic [dbbp_pkg::TIME_W-1:0]    frame_time_ms;
   modport source (output valid, depth_mm, frame_start, frame_time_ms, input ready);
   modport sink   (input valid, depth_mm, frame_start, frame_time_ms, output ready);
endinterface

interface dbbp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dbbp_pkg::POINT_W-1:0] point_x;
   logic signed [dbbp_pkg::POINT_W-1:0] point_y;
   logic [dbbp_pkg::DEPTH_W-1:0]        point_z;
   logic [dbbp_pkg::TIME_W-1:0]         elapsed_ms;
   modport source (output valid, point_x, point_y, point_z, elapsed_ms, input ready);
   modport sink   (input valid, point_x, point_y, point_z, elapsed_ms, output ready);
endinterface

interface dbbp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [dbbp_pkg::CSR_IDX_W-1:0]    index;
   logic [dbbp_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dbbp_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dbbp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dbbp_pkg::DIV_W-1:0]    dividend,
   input  logic [dbbp_pkg::CNT_W-1:0]    divisor,
   output logic                          busy,
   output logic [dbbp_pkg::DIV_W-1:0]    quotient,
   output logic [dbbp_pkg::CNT_W-1:0]    remainder
);
   localparam int STEP_W = $clog2(dbbp_pkg::DIV_W + 1);

   logic [dbbp_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [dbbp_pkg::CNT_W-1:0] rem_ff, rem_in, dvs_ff;
   logic [STEP_W-1:0]          step_ff;
   logic                       busy_ff;
   logic [dbbp_pkg::CNT_W:0]   trial, diff;
   logic                       ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[dbbp_pkg::DIV_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      ge     = trial >= {1'b0, dvs_ff};
      rem_in = ge ? diff[dbbp_pkg::CNT_W-1:0] : trial[dbbp_pkg::CNT_W-1:0];
      quo_in = {quo_ff[dbbp_pkg::DIV_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= STEP_W'(dbbp_pkg::DIV_W);
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) busy_ff <= 1'b0;
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// ===== rtl/core/dbbp_ctrl.sv =====
// Sequencer for one pixel request: frame decision, geometry resync, accumulate, project.
`timescale 1ns / 1ps
module dbbp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dbbp_pkg::status_type  status,
   output dbbp_pkg::cmd_type     cmd
);
   typedef enum logic [4:0] {
      S_IDLE, S_FRAME, S_CHECK, S_DCOL, S_WCOL, S_DROW, S_WROW, S_DWID, S_WWID,
      S_READ, S_ACC, S_DMEAN, S_WMEAN, S_MX1, S_MX2, S_MY1, S_MY2, S_OUT, S_ADV
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_FRAME;
         S_FRAME: state_in = S_CHECK;
         S_CHECK: begin
            if (!status.active)     state_in = S_IDLE;
            else if (status.resync) state_in = S_DCOL;
            else                    state_in = S_READ;
         end
         S_DCOL:  state_in = S_WCOL;
         S_WCOL:  if (!status.div_busy) state_in = S_DROW;
         S_DROW:  state_in = S_WROW;
         S_WROW:  if (!status.div_busy) state_in = S_DWID;
         S_DWID:  state_in = S_WWID;
         S_WWID:  if (!status.div_busy) state_in = S_READ;
         S_READ:  state_in = status.in_range ? S_ACC : S_ADV;
         S_ACC:   state_in = status.emit ? S_DMEAN : S_ADV;
         S_DMEAN: state_in = S_WMEAN;
         S_WMEAN: if (!status.div_busy) state_in = S_MX1;
         S_MX1:   state_in = S_MX2;
         S_MX2:   state_in = S_MY1;
         S_MY1:   state_in = S_MY2;
         S_MY2:   state_in = S_OUT;
         S_OUT:   if (status.out_free) state_in = S_ADV;
         S_ADV:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      case (state_ff)
         S_IDLE:  cmd.op = dbbp_pkg::OP_LATCH;
         S_FRAME: cmd.op = dbbp_pkg::OP_FRAME;
         S_DCOL:  cmd.op = dbbp_pkg::OP_DIV_COL;
         S_WCOL:  cmd.op = dbbp_pkg::OP_WAIT_COL;
         S_DROW:  cmd.op = dbbp_pkg::OP_DIV_ROW;
         S_WROW:  cmd.op = dbbp_pkg::OP_WAIT_ROW;
         S_DWID:  cmd.op = dbbp_pkg::OP_DIV_WID;
         S_WWID:  cmd.op = dbbp_pkg::OP_WAIT_WID;
         S_READ:  cmd.op = dbbp_pkg::OP_READ;
         S_ACC:   cmd.op = dbbp_pkg::OP_ACC;
         S_DMEAN: cmd.op = dbbp_pkg::OP_DIV_MEAN;
         S_WMEAN: cmd.op = dbbp_pkg::OP_WAIT_MEAN;
         S_MX1:   cmd.op = dbbp_pkg::OP_MUL1_X;
         S_MX2:   cmd.op = dbbp_pkg::OP_MUL2_X;
         S_MY1:   cmd.op = dbbp_pkg::OP_MUL1_Y;
         S_MY2:   cmd.op = dbbp_pkg::OP_MUL2_Y;
         S_OUT:   cmd.op = dbbp_pkg::OP_OUT;
         S_ADV:   cmd.op = dbbp_pkg::OP_ADV;
         default: cmd.op = dbbp_pkg::OP_NONE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
endmodule

// ===== rtl/core/dbbp_datapath.sv =====
// Registers, position counters, square accumulator memory, divider and projection math.
`timescale 1ns / 1ps
module dbbp_datapath #(
   parameter int MAX_WIDTH = dbbp_pkg::DEF_MAX_WIDTH,
   parameter int MAX_BLOCK = dbbp_pkg::DEF_MAX_BLOCK
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dbbp_pkg::cmd_type                    cmd,
   output dbbp_pkg::status_type                 status,
   input  logic                                 req_valid,
   input  logic [dbbp_pkg::DEPTH_W-1:0]         req_depth_mm,
   input  logic                                 req_frame_start,
   input  logic [dbbp_pkg::TIME_W-1:0]          req_frame_time_ms,
   input  logic                                 csr_valid,
   input  logic [dbbp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dbbp_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [dbbp_pkg::POINT_W-1:0]  rsp_point_x,
   output logic signed [dbbp_pkg::POINT_W-1:0]  rsp_point_y,
   output logic [dbbp_pkg::DEPTH_W-1:0]         rsp_point_z,
   output logic [dbbp_pkg::TIME_W-1:0]          rsp_elapsed_ms
);
   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int ENT_W = dbbp_pkg::SUM_W + dbbp_pkg::CNT_W;

   // configuration
   logic [dbbp_pkg::COL_W-1:0]   iw_ff;
   logic [dbbp_pkg::BS_W-1:0]    bs_ff;
   logic [dbbp_pkg::DEPTH_W-1:0] maxd_ff;
   logic [dbbp_pkg::SKIP_W-1:0]  skip_ff;
   logic [dbbp_pkg::INV_W-1:0]   ifx_ff, ify_ff;
   logic [dbbp_pkg::CEN_W-1:0]   cx_ff, cy_ff;

   // latched request
   logic [dbbp_pkg::DEPTH_W-1:0] depth_ff;
   logic                         start_ff;
   logic [dbbp_pkg::TIME_W-1:0]  tms_ff;

   // frame and position state
   logic [dbbp_pkg::COL_W-1:0]   col_ff, bc_ff, lim_ff;
   logic [dbbp_pkg::ROW_W-1:0]   row_ff;
   logic [dbbp_pkg::BS_W-1:0]    cin_ff, rin_ff;
   logic [dbbp_pkg::SKIP_W-1:0]  skipcnt_ff, skipcnt_in;
   logic                         active_ff, stv_ff, resync_ff;
   logic [dbbp_pkg::TIME_W-1:0]  st_ff, el_ff;

   // accumulator memory and math
   logic [ENT_W-1:0]             mem [MAX_WIDTH];
   logic [ENT_W-1:0]             rd_ff;
   logic [dbbp_pkg::SUM_W-1:0]   sum_ff, sum_in, base_sum;
   logic [dbbp_pkg::CNT_W-1:0]   cnt_ff, cnt_in, base_cnt;
   logic [dbbp_pkg::DEPTH_W-1:0] z_ff;
   logic [dbbp_pkg::P1_W-1:0]    p1_ff;
   logic [dbbp_pkg::P2_W-1:0]    p2_ff;
   logic                         negx_ff, negy_ff;
   logic [dbbp_pkg::POINT_W-1:0] px_ff;

   // result register
   logic                         rv_ff;
   logic [dbbp_pkg::POINT_W-1:0] rx_ff, ry_ff;
   logic [dbbp_pkg::DEPTH_W-1:0] rz_ff;
   logic [dbbp_pkg::TIME_W-1:0]  re_ff;

   logic [dbbp_pkg::COL_W-1:0]   w;
   logic [dbbp_pkg::BS_W-1:0]    b, bm1;
   logic                         first, pix_ok, col_wrap, out_free, load_out;
   logic [AW-1:0]                idx;
   logic [dbbp_pkg::POS_W-1:0]   centre, diff;
   logic [dbbp_pkg::CEN_W-1:0]   principal;
   logic [dbbp_pkg::INV_W-1:0]   inv;
   logic                         neg;
   logic                         div_start, div_busy;
   logic [dbbp_pkg::DIV_W-1:0]   div_a, div_q;
   logic [dbbp_pkg::CNT_W-1:0]   div_d, div_r;

   function automatic logic [dbbp_pkg::POINT_W-1:0] round_sat(
      input logic [dbbp_pkg::P2_W-1:0] p, input logic is_neg);
      logic [dbbp_pkg::P2_W:0]   sum;
      logic [dbbp_pkg::P2_W-28:0] mag;
      logic [dbbp_pkg::POINT_W-1:0] res;
      sum = {1'b0, p} + (dbbp_pkg::P2_W+1)'(64'd1 << 27);
      mag = sum[dbbp_pkg::P2_W:28];
      if (is_neg) begin
         if (mag > (dbbp_pkg::P2_W-27)'(131072)) res = 18'h20000;
         else res = 18'(~mag + 1'b1);
      end else begin
         if (mag > (dbbp_pkg::P2_W-27)'(131071)) res = 18'h1FFFF;
         else res = mag[dbbp_pkg::POINT_W-1:0];
      end
      return res;
   endfunction

   always_comb begin
      if (iw_ff == '0) w = dbbp_pkg::COL_W'(1);
      else if (32'(iw_ff) > MAX_WIDTH) w = dbbp_pkg::COL_W'(MAX_WIDTH);
      else w = iw_ff;
      if (bs_ff == '0) b = dbbp_pkg::BS_W'(1);
      else if (32'(bs_ff) > MAX_BLOCK) b = dbbp_pkg::BS_W'(MAX_BLOCK);
      else b = bs_ff;
      bm1 = b - 1'b1;

      skipcnt_in = (skipcnt_ff == dbbp_pkg::SKIP_NONE || skipcnt_ff >= skip_ff) ?
                   '0 : skipcnt_ff + 1'b1;

      idx      = AW'(bc_ff);
      first    = (rin_ff == '0) && (cin_ff == '0);
      pix_ok   = (depth_ff > dbbp_pkg::MIN_DEPTH) && (depth_ff < maxd_ff);
      base_sum = first ? '0 : rd_ff[ENT_W-1:dbbp_pkg::CNT_W];
      base_cnt = first ? '0 : rd_ff[dbbp_pkg::CNT_W-1:0];
      sum_in   = base_sum + (pix_ok ? dbbp_pkg::SUM_W'(depth_ff) : '0);
      cnt_in   = base_cnt + dbbp_pkg::CNT_W'(pix_ok);
      col_wrap = col_ff >= (w - 1'b1);

      // square centre in Q.4 pixels: start of square times 16 plus (b-1)*8
      if (cmd.op == dbbp_pkg::OP_MUL1_Y) begin
         centre    = (dbbp_pkg::POS_W'(row_ff - dbbp_pkg::ROW_W'(rin_ff)) << 4)
                     + dbbp_pkg::POS_W'({bm1, 3'b000});
         principal = cy_ff;
         inv       = ify_ff;
      end else begin
         centre    = (dbbp_pkg::POS_W'(col_ff - dbbp_pkg::COL_W'(cin_ff)) << 4)
                     + dbbp_pkg::POS_W'({bm1, 3'b000});
         principal = cx_ff;
         inv       = ifx_ff;
      end
      neg  = centre < dbbp_pkg::POS_W'(principal);
      diff = neg ? dbbp_pkg::POS_W'(principal) - centre : centre - dbbp_pkg::POS_W'(principal);

      div_start = 1'b0;
      div_a     = dbbp_pkg::DIV_W'(col_ff);
      div_d     = dbbp_pkg::CNT_W'(b);
      case (cmd.op)
         dbbp_pkg::OP_DIV_COL: div_start = 1'b1;
         dbbp_pkg::OP_DIV_ROW: begin
            div_start = 1'b1;
            div_a     = dbbp_pkg::DIV_W'(row_ff);
         end
         dbbp_pkg::OP_DIV_WID: begin
            div_start = 1'b1;
            div_a     = dbbp_pkg::DIV_W'(w);
         end
         dbbp_pkg::OP_DIV_MEAN: begin
            div_start = 1'b1;
            div_a     = dbbp_pkg::DIV_W'(sum_ff) + dbbp_pkg::DIV_W'(cnt_ff >> 1);
            div_d     = cnt_ff;
         end
         default: div_start = 1'b0;
      endcase

      out_free = !rv_ff || rsp_ready;
      load_out = (cmd.op == dbbp_pkg::OP_OUT) && out_free;
   end

   dbbp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_d),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // configuration and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff      <= dbbp_pkg::RST_WIDTH;
         bs_ff      <= dbbp_pkg::RST_BLOCK;
         maxd_ff    <= dbbp_pkg::RST_MAXD;
         skip_ff    <= dbbp_pkg::RST_SKIP;
         ifx_ff     <= dbbp_pkg::RST_INV_FX;
         ify_ff     <= dbbp_pkg::RST_INV_FY;
         cx_ff      <= dbbp_pkg::RST_CX;
         cy_ff      <= dbbp_pkg::RST_CY;
         col_ff     <= '0;
         row_ff     <= '0;
         bc_ff      <= '0;
         cin_ff     <= '0;
         rin_ff     <= '0;
         lim_ff     <= '0;
         skipcnt_ff <= dbbp_pkg::SKIP_NONE;
         active_ff  <= 1'b0;
         stv_ff     <= 1'b0;
         st_ff      <= '0;
         el_ff      <= '0;
         resync_ff  <= 1'b1;
         rv_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               dbbp_pkg::REG_IMAGE_WIDTH: begin
                  iw_ff     <= csr_data[dbbp_pkg::COL_W-1:0];
                  resync_ff <= 1'b1;
               end
               dbbp_pkg::REG_BLOCK_SIZE: begin
                  bs_ff     <= csr_data[dbbp_pkg::BS_W-1:0];
                  resync_ff <= 1'b1;
               end
               dbbp_pkg::REG_MAX_DEPTH:   maxd_ff <= csr_data[dbbp_pkg::DEPTH_W-1:0];
               dbbp_pkg::REG_SKIP_FRAMES: skip_ff <= csr_data[dbbp_pkg::SKIP_W-1:0];
               dbbp_pkg::REG_INV_FX:      ifx_ff  <= csr_data[dbbp_pkg::INV_W-1:0];
               dbbp_pkg::REG_INV_FY:      ify_ff  <= csr_data[dbbp_pkg::INV_W-1:0];
               dbbp_pkg::REG_CENTER_X:    cx_ff   <= csr_data[dbbp_pkg::CEN_W-1:0];
               dbbp_pkg::REG_CENTER_Y:    cy_ff   <= csr_data[dbbp_pkg::CEN_W-1:0];
               default: ;
            endcase
         end

         case (cmd.op)
            dbbp_pkg::OP_FRAME: begin
               if (start_ff) begin
                  skipcnt_ff <= skipcnt_in;
                  if (skipcnt_in == '0) begin
                     active_ff <= 1'b1;
                     col_ff    <= '0;
                     row_ff    <= '0;
                     bc_ff     <= '0;
                     cin_ff    <= '0;
                     rin_ff    <= '0;
                     if (!stv_ff) begin
                        st_ff  <= tms_ff;
                        stv_ff <= 1'b1;
                        el_ff  <= '0;
                     end else begin
                        el_ff  <= tms_ff - st_ff;
                     end
                  end else begin
                     active_ff <= 1'b0;
                  end
               end
            end
            dbbp_pkg::OP_WAIT_COL: if (!div_busy) begin
               bc_ff  <= div_q[dbbp_pkg::COL_W-1:0];
               cin_ff <= div_r[dbbp_pkg::BS_W-1:0];
            end
            dbbp_pkg::OP_WAIT_ROW: if (!div_busy) rin_ff <= div_r[dbbp_pkg::BS_W-1:0];
            dbbp_pkg::OP_WAIT_WID: if (!div_busy) begin
               lim_ff    <= dbbp_pkg::COL_W'(div_q[dbbp_pkg::COL_W-1:0] * b);
               resync_ff <= 1'b0;
            end
            dbbp_pkg::OP_ADV: begin
               if (col_wrap) begin
                  col_ff <= '0;
                  cin_ff <= '0;
                  bc_ff  <= '0;
                  row_ff <= row_ff + 1'b1;
                  // 16-bit row wrap lands on row 0, which is a square's first row
                  if (row_ff == '1 || rin_ff == bm1) rin_ff <= '0;
                  else rin_ff <= rin_ff + 1'b1;
               end else begin
                  col_ff <= col_ff + 1'b1;
                  if (cin_ff == bm1) begin
                     cin_ff <= '0;
                     bc_ff  <= bc_ff + 1'b1;
                  end else begin
                     cin_ff <= cin_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase

         if (load_out) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         dbbp_pkg::OP_LATCH: if (req_valid) begin
            depth_ff <= req_depth_mm;
            start_ff <= req_frame_start;
            tms_ff   <= req_frame_time_ms;
         end
         dbbp_pkg::OP_READ: rd_ff <= mem[idx];
         dbbp_pkg::OP_ACC: begin
            mem[idx] <= {sum_in, cnt_in};
            sum_ff   <= sum_in;
            cnt_ff   <= cnt_in;
         end
         dbbp_pkg::OP_WAIT_MEAN: if (!div_busy) z_ff <= div_q[dbbp_pkg::DEPTH_W-1:0];
         dbbp_pkg::OP_MUL1_X: begin
            p1_ff   <= diff * inv;
            negx_ff <= neg;
         end
         dbbp_pkg::OP_MUL1_Y: begin
            p1_ff   <= diff * inv;
            negy_ff <= neg;
            px_ff   <= round_sat(p2_ff, negx_ff);
         end
         dbbp_pkg::OP_MUL2_X,
         dbbp_pkg::OP_MUL2_Y: p2_ff <= p1_ff * z_ff;
         default: ;
      endcase
      if (load_out) begin
         rx_ff <= px_ff;
         ry_ff <= round_sat(p2_ff, negy_ff);
         rz_ff <= z_ff;
         re_ff <= el_ff;
      end
   end

   always_comb begin
      status.active   = active_ff;
      status.resync   = resync_ff;
      status.in_range = col_ff < lim_ff;
      status.emit     = (rin_ff == bm1) && (cin_ff == bm1) && (cnt_in != '0);
      status.div_busy = div_busy;
      status.out_free = out_free;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_point_x    = rx_ff;
   assign rsp_point_y    = ry_ff;
   assign rsp_point_z    = rz_ff;
   assign rsp_elapsed_ms = re_ff;
endmodule

// ===== rtl/core/depth_block_backprojector_unit.sv =====
// Top level of the depth block back-projector.
//
//  channel  dir   handshake     payload
//  req_ch   in    valid/ready   depth_mm, frame_start, frame_time_ms
//  rsp_ch   out   valid/ready   point_x, point_y, point_z, elapsed_ms
//  csr_ch   in    valid/ready   index, data (ready always high)
//
// A pixel request holds the sequencer until it is through: the sequencer runs one request at
// a time, and a request that completes a square also waits on the 23-step serial divider
// forming the mean depth. After reset or a write to image_width or block_size the next
// passed pixel also waits on the divider while it rebuilds column, square and row
// counters. Synchronous reset clears all control state. A stalled result holds in its
// output register; the next request is taken meanwhile and waits only when it has a new
// point to deliver.
`timescale 1ns / 1ps
module depth_block_backprojector_unit #(
   parameter int MAX_WIDTH = dbbp_pkg::DEF_MAX_WIDTH,
   parameter int MAX_BLOCK = dbbp_pkg::DEF_MAX_BLOCK
) (
   input  logic        clock,
   input  logic        reset,
   dbbp_req_if.sink    req_ch,
   dbbp_rsp_if.source  rsp_ch,
   dbbp_csr_if.sink    csr_ch
);
   dbbp_pkg::cmd_type    cmd;
   dbbp_pkg::status_type status;
   logic                 req_ready;

   dbbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dbbp_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_valid         (req_ch.valid),
      .req_depth_mm      (req_ch.depth_mm),
      .req_frame_start   (req_ch.frame_start),
      .req_frame_time_ms (req_ch.frame_time_ms),
      .csr_valid         (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_point_x       (rsp_ch.point_x),
      .rsp_point_y       (rsp_ch.point_y),
      .rsp_point_z       (rsp_ch.point_z),
      .rsp_elapsed_ms    (rsp_ch.elapsed_ms)
   );

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   // one request in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while another is in flight");

   // a point handed to a free output register shows up next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == dbbp_pkg::OP_OUT && status.out_free |=> rsp_ch.valid)
      else $error("result load lost");

   // the divider is never restarted mid-division
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == dbbp_pkg::OP_DIV_COL || cmd.op == dbbp_pkg::OP_DIV_ROW ||
       cmd.op == dbbp_pkg::OP_DIV_WID || cmd.op == dbbp_pkg::OP_DIV_MEAN)
      |-> !status.div_busy)
      else $error("divider started while busy");
endmodule
